// File: design/ray_mesh_nearest_hit_unit_assert.svh
// ----------------------------------------------------------------------------
// Ray mesh nearest hit unit assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef RAY_MESH_NEAREST_HIT_UNIT_ASSERT_SVH
`define RAY_MESH_NEAREST_HIT_UNIT_ASSERT_SVH

// clocked, disabled while reset is high
`define RMNH_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rmnh assertion failed");

// clocked, also checked during reset
`define RMNH_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("rmnh assertion failed");

`endif

// File: design/rmnh_pkg.sv
// ----------------------------------------------------------------------------
// Ray mesh nearest hit package
// Shared types, constants and saturation helper.
// ----------------------------------------------------------------------------
package rmnh_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int QDEPTH        = 2;

   typedef enum logic [2:0] {
      REG_ORIGIN_X = 3'd0,
      REG_ORIGIN_Y = 3'd1,
      REG_ORIGIN_Z = 3'd2,
      REG_DIR_X    = 3'd3,
      REG_DIR_Y    = 3'd4,
      REG_DIR_Z    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [2:0][31:0] e1;
      logic [2:0][31:0] e2;
      logic [2:0][31:0] s;
      logic             last;
   } entry_type;

   typedef struct packed {
      logic             hit;
      logic [30:0]      distance;
      logic [2:0][31:0] point;
   } result_type;

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: design/rmnh_front.sv
// ----------------------------------------------------------------------------
// Ray mesh nearest hit front end
// Accepts triangles and forms the saturated edge and origin offset vectors.
// ----------------------------------------------------------------------------
module rmnh_front import rmnh_pkg::*; (
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [287:0]     req_tdata,
   input  logic             req_tlast,
   input  logic [2:0][31:0] origin,
   input  logic             queue_full,
   output logic             push,
   output entry_type        entry
);

   logic [31:0] va [3];
   logic [31:0] vb [3];
   logic [31:0] vc [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         va[i] = req_tdata[32*i +: 32];
         vb[i] = req_tdata[32*(3+i) +: 32];
         vc[i] = req_tdata[32*(6+i) +: 32];
      end
   end

   always_comb begin
      entry.last = req_tlast;
      for (int i = 0; i < 3; i++) begin
         entry.e1[i] = sat32(64'($signed(vb[i])) - 64'($signed(va[i])));
         entry.e2[i] = sat32(64'($signed(vc[i])) - 64'($signed(va[i])));
         entry.s[i]  = sat32(64'($signed(origin[i])) - 64'($signed(va[i])));
      end
   end

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

endmodule

// File: design/rmnh_queue.sv
// ----------------------------------------------------------------------------
// Ray mesh nearest hit queue
// Short queue of prepared triangles between front end and back end.
// ----------------------------------------------------------------------------
module rmnh_queue import rmnh_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type head
);

   localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CNTW = $clog2(QDEPTH + 1);

   entry_type       mem [QDEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   rd_ptr_ff;
   logic [CNTW-1:0] count_ff;

   assign full      = (count_ff == CNTW'(QDEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: design/rmnh_back.sv
// ----------------------------------------------------------------------------
// Ray mesh nearest hit back end
// Shared multiply-accumulate and bit-serial divider run the triangle test,
// track the nearest hit and form the result on the last triangle.
// ----------------------------------------------------------------------------
module rmnh_back import rmnh_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             entry_valid,
   input  entry_type        entry,
   output logic             pop,
   input  logic [2:0][31:0] origin,
   input  logic [2:0][31:0] dir,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output result_type       result
);

   localparam int NW   = 32 + FRAC_BITS;
   localparam int CNTW = $clog2(NW + 1);
   localparam logic signed [NW:0]   ONE  = (NW+1)'(1) <<< FRAC_BITS;
   localparam logic signed [NW+1:0] ONE2 = (NW+2)'(1) <<< FRAC_BITS;
   localparam logic signed [NW:0]   TMAX = {{(NW-30){1'b0}}, {31{1'b1}}};

   typedef enum logic [2:0] {
      SRC_DIR, SRC_E1, SRC_E2, SRC_S, SRC_P, SRC_Q
   } src_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_P0, DST_P1, DST_P2, DST_DET, DST_SP,
      DST_Q0, DST_Q1, DST_Q2, DST_DQ, DST_EQ
   } dst_type;

   typedef struct packed {
      src_type    a_src;
      logic [1:0] a_idx;
      src_type    b_src;
      logic [1:0] b_idx;
      logic       neg;
      dst_type    dst;
   } mac_op_type;

   typedef enum logic [1:0] {DK_U, DK_V, DK_T} div_kind_type;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_ACC, S_DIVLD, S_DIV, S_DIVEND, S_FIN, S_PMUL, S_PACC
   } state_type;

   function automatic mac_op_type mac_op(input logic [4:0] k);
      mac_op_type o;
      case (k)
         5'd0:  o = '{SRC_DIR, 2'd1, SRC_E2, 2'd2, 1'b0, DST_NONE};
         5'd1:  o = '{SRC_DIR, 2'd2, SRC_E2, 2'd1, 1'b1, DST_P0};
         5'd2:  o = '{SRC_DIR, 2'd2, SRC_E2, 2'd0, 1'b0, DST_NONE};
         5'd3:  o = '{SRC_DIR, 2'd0, SRC_E2, 2'd2, 1'b1, DST_P1};
         5'd4:  o = '{SRC_DIR, 2'd0, SRC_E2, 2'd1, 1'b0, DST_NONE};
         5'd5:  o = '{SRC_DIR, 2'd1, SRC_E2, 2'd0, 1'b1, DST_P2};
         5'd6:  o = '{SRC_E1,  2'd0, SRC_P,  2'd0, 1'b0, DST_NONE};
         5'd7:  o = '{SRC_E1,  2'd1, SRC_P,  2'd1, 1'b0, DST_NONE};
         5'd8:  o = '{SRC_E1,  2'd2, SRC_P,  2'd2, 1'b0, DST_DET};
         5'd9:  o = '{SRC_S,   2'd0, SRC_P,  2'd0, 1'b0, DST_NONE};
         5'd10: o = '{SRC_S,   2'd1, SRC_P,  2'd1, 1'b0, DST_NONE};
         5'd11: o = '{SRC_S,   2'd2, SRC_P,  2'd2, 1'b0, DST_SP};
         5'd12: o = '{SRC_S,   2'd1, SRC_E1, 2'd2, 1'b0, DST_NONE};
         5'd13: o = '{SRC_S,   2'd2, SRC_E1, 2'd1, 1'b1, DST_Q0};
         5'd14: o = '{SRC_S,   2'd2, SRC_E1, 2'd0, 1'b0, DST_NONE};
         5'd15: o = '{SRC_S,   2'd0, SRC_E1, 2'd2, 1'b1, DST_Q1};
         5'd16: o = '{SRC_S,   2'd0, SRC_E1, 2'd1, 1'b0, DST_NONE};
         5'd17: o = '{SRC_S,   2'd1, SRC_E1, 2'd0, 1'b1, DST_Q2};
         5'd18: o = '{SRC_DIR, 2'd0, SRC_Q,  2'd0, 1'b0, DST_NONE};
         5'd19: o = '{SRC_DIR, 2'd1, SRC_Q,  2'd1, 1'b0, DST_NONE};
         5'd20: o = '{SRC_DIR, 2'd2, SRC_Q,  2'd2, 1'b0, DST_DQ};
         5'd21: o = '{SRC_E2,  2'd0, SRC_Q,  2'd0, 1'b0, DST_NONE};
         5'd22: o = '{SRC_E2,  2'd1, SRC_Q,  2'd1, 1'b0, DST_NONE};
         5'd23: o = '{SRC_E2,  2'd2, SRC_Q,  2'd2, 1'b0, DST_EQ};
         default: o = '{SRC_DIR, 2'd0, SRC_DIR, 2'd0, 1'b0, DST_NONE};
      endcase
      return o;
   endfunction

   function automatic logic [31:0] pick(input logic [2:0][31:0] v, input logic [1:0] i);
      logic [31:0] r;
      case (i)
         2'd1:    r = v[1];
         2'd2:    r = v[2];
         default: r = v[0];
      endcase
      return r;
   endfunction

   state_type        state_ff;
   logic [4:0]       pc_ff;
   logic [1:0]       pidx_ff;
   div_kind_type     kind_ff;
   logic [2:0][31:0] e1_ff, e2_ff, s_ff, p_ff, q_ff;
   logic             last_ff;
   logic [31:0]      det_ff, sp_ff, dq_ff, eq_ff;
   logic signed [63:0] prod_ff;
   logic signed [63:0] acc_ff;
   logic [NW-1:0]    nq_ff;
   logic [31:0]      rem_ff;
   logic [31:0]      dvs_ff;
   logic             qneg_ff;
   logic [CNTW-1:0]  cnt_ff;
   logic signed [NW:0] u_ff;
   logic [30:0]      best_ff;
   logic             any_hit_ff;
   logic             out_valid_ff;
   result_type       out_ff;

   mac_op_type         op;
   logic [31:0]        mul_a, mul_b;
   logic signed [63:0] prod_in;
   logic signed [63:0] term;
   logic signed [63:0] sum;
   logic [31:0]        sum_sat;
   logic [32:0]        rem_sh;
   logic               ge;
   logic [32:0]        rem_sub;
   logic signed [NW:0] quo;
   logic [31:0]        dnum;
   logic [31:0]        dnum_mag;
   logic [31:0]        det_mag;
   logic [30:0]        t_sat;
   logic [31:0]        pt;
   logic               out_free;
   logic               out_load;

   function automatic logic [2:0][31:0] vec(
      input src_type s, input logic [2:0][31:0] d, input logic [2:0][31:0] a1,
      input logic [2:0][31:0] a2, input logic [2:0][31:0] as,
      input logic [2:0][31:0] ap, input logic [2:0][31:0] aq);
      logic [2:0][31:0] r;
      case (s)
         SRC_E1:  r = a1;
         SRC_E2:  r = a2;
         SRC_S:   r = as;
         SRC_P:   r = ap;
         SRC_Q:   r = aq;
         default: r = d;
      endcase
      return r;
   endfunction

   always_comb begin
      op = mac_op(pc_ff);
      if (state_ff == S_PMUL) begin
         mul_a = pick(dir, pidx_ff);
         mul_b = {1'b0, best_ff};
      end else begin
         mul_a = pick(vec(op.a_src, dir, e1_ff, e2_ff, s_ff, p_ff, q_ff), op.a_idx);
         mul_b = pick(vec(op.b_src, dir, e1_ff, e2_ff, s_ff, p_ff, q_ff), op.b_idx);
      end
      prod_in = $signed(mul_a) * $signed(mul_b);
      term    = prod_ff >>> FRAC_BITS;
      sum     = op.neg ? acc_ff - term : acc_ff + term;
      sum_sat = sat32(sum);
      rem_sh  = {rem_ff, nq_ff[NW-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      rem_sub = ge ? rem_sh - {1'b0, dvs_ff} : rem_sh;
      quo     = qneg_ff ? -$signed({1'b0, nq_ff}) : $signed({1'b0, nq_ff});
      case (kind_ff)
         DK_U:    dnum = sp_ff;
         DK_V:    dnum = dq_ff;
         default: dnum = eq_ff;
      endcase
      dnum_mag = dnum[31] ? -dnum : dnum;
      det_mag  = det_ff[31] ? -det_ff : det_ff;
      t_sat    = (quo > TMAX) ? 31'h7fff_ffff : quo[30:0];
      pt       = sat32(64'($signed(pick(origin, pidx_ff))) + term);
      out_free = !out_valid_ff || rsp_tready;
      out_load = (state_ff == S_FIN && last_ff && out_free && !any_hit_ff) ||
                 (state_ff == S_PACC && pidx_ff == 2'd2);
   end

   assign pop        = (state_ff == S_IDLE) && entry_valid;
   assign rsp_tvalid = out_valid_ff;
   assign result     = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         pidx_ff      <= '0;
         kind_ff      <= DK_U;
         acc_ff       <= '0;
         best_ff      <= '1;
         any_hit_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (entry_valid) begin
                  e1_ff    <= entry.e1;
                  e2_ff    <= entry.e2;
                  s_ff     <= entry.s;
                  last_ff  <= entry.last;
                  pc_ff    <= '0;
                  acc_ff   <= '0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (op.dst == DST_NONE) begin
                  acc_ff   <= sum;
                  pc_ff    <= pc_ff + 1'b1;
                  state_ff <= S_MUL;
               end else begin
                  acc_ff   <= '0;
                  pc_ff    <= pc_ff + 1'b1;
                  case (op.dst)
                     DST_P0:  p_ff[0] <= sum_sat;
                     DST_P1:  p_ff[1] <= sum_sat;
                     DST_P2:  p_ff[2] <= sum_sat;
                     DST_Q0:  q_ff[0] <= sum_sat;
                     DST_Q1:  q_ff[1] <= sum_sat;
                     DST_Q2:  q_ff[2] <= sum_sat;
                     DST_DET: det_ff  <= sum_sat;
                     DST_SP: begin
                        sp_ff   <= sum_sat;
                        kind_ff <= DK_U;
                     end
                     DST_DQ: begin
                        dq_ff   <= sum_sat;
                        kind_ff <= DK_V;
                     end
                     DST_EQ: begin
                        eq_ff   <= sum_sat;
                        kind_ff <= DK_T;
                     end
                     default: ;
                  endcase
                  case (op.dst) inside
                     DST_DET:                state_ff <= (sum_sat == '0) ? S_FIN : S_MUL;
                     DST_SP, DST_DQ, DST_EQ: state_ff <= S_DIVLD;
                     default:                state_ff <= S_MUL;
                  endcase
               end
            end
            S_DIVLD: begin
               nq_ff    <= {dnum_mag, {FRAC_BITS{1'b0}}};
               rem_ff   <= '0;
               dvs_ff   <= det_mag;
               qneg_ff  <= dnum[31] ^ det_ff[31];
               cnt_ff   <= CNTW'(NW);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_ff <= rem_sub[31:0];
               nq_ff  <= {nq_ff[NW-2:0], ge};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CNTW'(1)) begin
                  state_ff <= S_DIVEND;
               end
            end
            S_DIVEND: begin
               case (kind_ff)
                  DK_U: begin
                     u_ff <= quo;
                     state_ff <= (quo < 0 || quo > ONE) ? S_FIN : S_MUL;
                  end
                  DK_V: begin
                     if (quo < 0 || ($signed({u_ff[NW], u_ff}) +
                                     $signed({quo[NW], quo})) > ONE2) begin
                        state_ff <= S_FIN;
                     end else begin
                        state_ff <= S_MUL;
                     end
                  end
                  default: begin
                     if (quo > 0 && (!any_hit_ff || t_sat < best_ff)) begin
                        best_ff    <= t_sat;
                        any_hit_ff <= 1'b1;
                     end
                     state_ff <= S_FIN;
                  end
               endcase
            end
            S_FIN: begin
               if (!last_ff) begin
                  state_ff <= S_IDLE;
               end else if (out_free) begin
                  if (any_hit_ff) begin
                     pidx_ff  <= '0;
                     state_ff <= S_PMUL;
                  end else begin
                     out_ff   <= '0;
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_PMUL: begin
               prod_ff  <= prod_in;
               state_ff <= S_PACC;
            end
            S_PACC: begin
               out_ff.point[pidx_ff] <= pt;
               if (pidx_ff == 2'd2) begin
                  out_ff.hit      <= 1'b1;
                  out_ff.distance <= best_ff;
                  best_ff         <= '1;
                  any_hit_ff      <= 1'b0;
                  state_ff        <= S_IDLE;
               end else begin
                  pidx_ff  <= pidx_ff + 1'b1;
                  state_ff <= S_PMUL;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: design/ray_mesh_nearest_hit_unit.sv
// A triangle runs multiply-accumulate steps and up to three divides on the
// single shared multiplier and the one-bit-a-cycle divider. Rejected triangles
// finish early; the last triangle with a hit adds the point on the multiplier.
// Triangles are tested one at a time; the front accepts into a 2-entry queue,
// and the last triangle waits until an earlier result has been taken.
// Reset: synchronous, active high; clears control state and restores registers.
// ----------------------------------------------------------------------------
// Ray mesh nearest hit unit
// Nearest ray/triangle hit over a streamed mesh, fixed point.
// ----------------------------------------------------------------------------
module ray_mesh_nearest_hit_unit import rmnh_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
   input  logic [287:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit_distance, point_x, point_y, point_z, zero pad
   output logic [127:0] rsp_tdata,
   // hit
   output logic         rsp_tuser,
   input  logic         csr_wen,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   logic [2:0][31:0] origin_ff;
   logic [2:0][31:0] dir_ff;
   logic             queue_full;
   logic             push;
   entry_type        push_entry;
   logic             pop;
   logic             not_empty;
   entry_type        head;
   result_type       result;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
         dir_ff    <= {32'h0001_0000, 32'h0, 32'h0};
      end else if (csr_wen) begin
         case (csr_index)
            REG_ORIGIN_X: origin_ff[0] <= csr_wdata;
            REG_ORIGIN_Y: origin_ff[1] <= csr_wdata;
            REG_ORIGIN_Z: origin_ff[2] <= csr_wdata;
            REG_DIR_X:    dir_ff[0]    <= csr_wdata;
            REG_DIR_Y:    dir_ff[1]    <= csr_wdata;
            REG_DIR_Z:    dir_ff[2]    <= csr_wdata;
            default: ;
         endcase
      end
   end

   rmnh_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .origin     (origin_ff),
      .queue_full (queue_full),
      .push       (push),
      .entry      (push_entry)
   );

   rmnh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head)
   );

   rmnh_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (not_empty),
      .entry       (head),
      .pop         (pop),
      .origin      (origin_ff),
      .dir         (dir_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .result      (result)
   );

   assign rsp_tuser = result.hit;
   assign rsp_tdata = {1'b0, result.point[2], result.point[1], result.point[0],
                       result.distance};

endmodule

// File: design/rmnh_checker.sv
// ----------------------------------------------------------------------------
// Ray mesh nearest hit checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "ray_mesh_nearest_hit_unit_assert.svh"

module rmnh_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic         rsp_tuser
);

   `RMNH_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `RMNH_ASSERT(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
   `RMNH_ASSERT(a_hit_dist, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tdata[30:0] != '0)
   `RMNH_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid)

endmodule

bind ray_mesh_nearest_hit_unit rmnh_checker u_rmnh_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
